[rtl/mbet_pkg.sv]
// shared types and constants for the escape-time iteration core
`timescale 1ns / 1ps

package mbet_pkg;

    localparam int Z_W   = 32;
    localparam int C_W   = 30;
    localparam int CNT_W = 8;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;
    localparam logic [CNT_W-1:0] MAX_ITER_RESET = 8'd100;

    // one point in flight around the ring
    typedef struct packed {
        logic                    done;
        logic [CNT_W-1:0]        count;
        logic signed [Z_W-1:0]   zr;
        logic signed [Z_W-1:0]   zi;
        logic signed [C_W-1:0]   cr;
        logic signed [C_W-1:0]   ci;
    } token_t;

endpackage

[rtl/mandelbrot_escape_time_core.sv]
// escape-time core: a ring of iteration cells with one point in flight
// a point passes through the product and escape-test registers of each cell, one iteration per cell,
// until it is done; it reaches m_axis_tvalid when the output register is free, and waits while it is full
// throughput: one point at a time; a new point is taken the cycle after the previous
// result has moved into the output register
// reset (rst_n, async, active low): ring and output empty, max_iterations = 100
`timescale 1ns / 1ps

module mandelbrot_escape_time_core #(
    parameter int FRAC_BITS = 27,
    parameter int NUM_CELLS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [mbet_pkg::CNT_W-1:0]           cfg_wr_data,    // max_iterations
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [mbet_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // c_real[29:0], c_imag[59:30]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [mbet_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // iteration_count[7:0]
);
    import mbet_pkg::*;

    logic [CNT_W-1:0]   max_iter_reg;
    logic               busy_reg;
    logic               in_accept;

    logic               cell_in_valid  [NUM_CELLS];
    token_t             cell_in_tok    [NUM_CELLS];
    logic               cell_out_valid [NUM_CELLS];
    token_t             cell_out_tok   [NUM_CELLS];
    logic               pass_valid     [NUM_CELLS];

    token_t             new_tok;
    logic               fin_any;
    logic [CNT_W-1:0]   fin_count;
    logic               capture;

    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_count_reg;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_iter_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        new_tok.done  = 1'b0;
        new_tok.count = '0;
        new_tok.zr    = '0;
        new_tok.zi    = '0;
        new_tok.cr    = s_axis_tdata[C_W-1:0];
        new_tok.ci    = s_axis_tdata[2*C_W-1:C_W];
    end

    // find the finished point, if any; at most one token is in the ring
    always_comb
    begin
        fin_any   = 1'b0;
        fin_count = '0;
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            if (cell_out_valid[k] && cell_out_tok[k].done)
            begin
                fin_any   = 1'b1;
                fin_count = fin_count | cell_out_tok[k].count;
            end
        end
        capture = fin_any && (!out_valid_reg || m_axis_tready);
        // a finished token keeps circulating until the output register takes it
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            pass_valid[k] = cell_out_valid[k] && !(cell_out_tok[k].done && capture);
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            always_comb
            begin
                cell_in_valid[g] = in_accept || pass_valid[NUM_CELLS-1];
                cell_in_tok[g]   = in_accept ? new_tok : cell_out_tok[NUM_CELLS-1];
            end
        end
        else
        begin : g_link
            always_comb
            begin
                cell_in_valid[g] = pass_valid[g-1];
                cell_in_tok[g]   = cell_out_tok[g-1];
            end
        end

        mbet_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .max_iterations (max_iter_reg),
            .tok_valid_in   (cell_in_valid[g]),
            .tok_in         (cell_in_tok[g]),
            .tok_valid_out  (cell_out_valid[g]),
            .tok_out        (cell_out_tok[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (capture)
            begin
                busy_reg <= 1'b0;
            end

            if (capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            out_count_reg <= fin_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;

endmodule

[rtl/mbet_cell.sv]
// one iteration cell: product stage, then combine and escape-test stage
`timescale 1ns / 1ps

module mbet_cell #(
    parameter int FRAC_BITS = 27
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mbet_pkg::CNT_W-1:0]        max_iterations,
    input  logic                              tok_valid_in,
    input  mbet_pkg::token_t                  tok_in,
    output logic                              tok_valid_out,
    output mbet_pkg::token_t                  tok_out
);
    import mbet_pkg::*;

    localparam int PROD_W = 2 * Z_W;
    localparam int RR_W   = PROD_W - FRAC_BITS;
    localparam int SUM_A  = RR_W + 1;
    localparam int SUM_B  = FRAC_BITS + 4;
    localparam int SUM_W  = (SUM_A > SUM_B) ? SUM_A : SUM_B;
    localparam logic signed [SUM_W-1:0] FOUR = SUM_W'(4) << FRAC_BITS;

    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic [CNT_W-1:0]         count_inc;

    logic                     s1_valid_reg;
    logic                     s1_done_reg;
    logic                     s1_stop_reg;
    logic [CNT_W-1:0]         s1_count_reg;
    logic signed [RR_W-1:0]   rr_reg;
    logic signed [RR_W-1:0]   ii_reg;
    logic signed [Z_W-1:0]    ri_reg;
    logic signed [Z_W-1:0]    zr_hold_reg;
    logic signed [Z_W-1:0]    zi_hold_reg;
    logic signed [C_W-1:0]    cr_reg;
    logic signed [C_W-1:0]    ci_reg;

    logic signed [SUM_W-1:0]  mag;
    logic                     escape;
    logic signed [Z_W-1:0]    zr_new;
    logic signed [Z_W-1:0]    zi_new;
    token_t                   out_next;
    logic                     out_valid_reg;
    token_t                   out_reg;

    // stage 1: full-precision products, truncated toward minus infinity
    always_comb
    begin
        p_rr      = tok_in.zr * tok_in.zr;
        p_ii      = tok_in.zi * tok_in.zi;
        p_ri      = tok_in.zr * tok_in.zi;
        count_inc = tok_in.count + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_done_reg  <= tok_in.done;
        s1_stop_reg  <= (count_inc >= max_iterations);
        s1_count_reg <= tok_in.done ? tok_in.count : count_inc;
        rr_reg       <= RR_W'(p_rr >>> FRAC_BITS);
        ii_reg       <= RR_W'(p_ii >>> FRAC_BITS);
        ri_reg       <= Z_W'(p_ri >>> (FRAC_BITS - 1));
        zr_hold_reg  <= tok_in.zr;
        zi_hold_reg  <= tok_in.zi;
        cr_reg       <= tok_in.cr;
        ci_reg       <= tok_in.ci;
    end

    // stage 2: escape test and z update, wrapping to the z width
    always_comb
    begin
        mag    = SUM_W'(rr_reg) + SUM_W'(ii_reg);
        escape = (mag >= FOUR);
        zr_new = Z_W'(rr_reg) - Z_W'(ii_reg) + Z_W'(cr_reg);
        zi_new = ri_reg + Z_W'(ci_reg);

        out_next.count = s1_count_reg;
        out_next.cr    = cr_reg;
        out_next.ci    = ci_reg;
        if (s1_done_reg || s1_stop_reg || escape)
        begin
            out_next.done = 1'b1;
            out_next.zr   = zr_hold_reg;
            out_next.zi   = zi_hold_reg;
        end
        else
        begin
            out_next.done = 1'b0;
            out_next.zr   = zr_new;
            out_next.zi   = zi_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign tok_valid_out = out_valid_reg;
    assign tok_out       = out_reg;

endmodule

[rtl/mbet_checker.sv]
// port-level checks for the escape-time core, bound to the top level
`timescale 1ns / 1ps

module mbet_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [mbet_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import mbet_pkg::*;

    // one point at a time: taking a point closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after a transaction");

    // input reopens only when its result has reached the output
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid)
        else $error("input reopened without a result");

    // the counter is pre-incremented, so a result is never zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != '0))
        else $error("zero iteration count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time_core mbet_checker u_mbet_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/testbench.sv]
// self-checking testbench for the escape-time iteration core: random points, limits and stalls
`timescale 1ns / 1ps

module testbench;

    import mbet_pkg::*;

    localparam int FRAC = 27;
    localparam longint ESCAPE_RADIUS_SQ = longint'(4) << FRAC;
    localparam int UNIT = 1 << FRAC;
    localparam int C_MIN = -(1 << (C_W - 1));
    localparam int C_MAX = (1 << (C_W - 1)) - 1;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 600;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [C_W-1:0] c_re;
        logic signed [C_W-1:0] c_im;
    } point_t;

    typedef struct {
        logic signed [C_W-1:0] c_re;
        logic signed [C_W-1:0] c_im;
        logic [CNT_W-1:0]      count;
    } escape_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // c_real[29:0], c_imag[59:30]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // iteration_count[7:0]

    point_t         pending_points[$];
    escape_result_t expected_counts[$];
    logic [CNT_W-1:0] iter_limit = MAX_ITER_RESET;

    int mismatches = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    point_t tx_item;
    escape_result_t accepted_point;
    escape_result_t want;

    mandelbrot_escape_time_core #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // iterate z = z*z + c from zero; count is bumped before each step
    function automatic logic [CNT_W-1:0] escape_count(input logic signed [C_W-1:0] c_re,
                                                      input logic signed [C_W-1:0] c_im,
                                                      input logic [CNT_W-1:0] limit);
        logic signed [Z_W-1:0] zr;
        logic signed [Z_W-1:0] zi;
        longint re_sq;
        longint im_sq;
        longint cross_term;
        longint next_re;
        longint next_im;
        int count;
        zr = '0;
        zi = '0;
        count = 0;
        forever
        begin
            count++;
            if (count >= limit)
                break;
            re_sq = (longint'(zr) * longint'(zr)) >>> FRAC;
            im_sq = (longint'(zi) * longint'(zi)) >>> FRAC;
            if (re_sq + im_sq >= ESCAPE_RADIUS_SQ)
                break;
            // doubling folded into the shift so the exact product is truncated once
            cross_term = (longint'(zr) * longint'(zi)) >>> (FRAC - 1);
            next_re = re_sq - im_sq + longint'(c_re);
            next_im = cross_term + longint'(c_im);
            zr = next_re[Z_W-1:0];
            zi = next_im[Z_W-1:0];
        end
        return count[CNT_W-1:0];
    endfunction

    // mostly back-to-back, sometimes short or long pauses, now and then a calm run
    function automatic int idle_len(inout int calm_run);
        int r;
        if (calm_run > 0)
        begin
            calm_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_run = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_edge_value();
        case ($urandom_range(0, 6))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return ($urandom_range(0, 1) != 0) ? 2 * UNIT : -2 * UNIT;
            default: return int'($urandom());
        endcase
    endfunction

    task automatic queue_point(input int re, input int im);
        point_t p;
        p.c_re = re[C_W-1:0];
        p.c_im = im[C_W-1:0];
        pending_points.push_back(p);
    endtask

    task automatic queue_random_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            // window around the set, where long orbits live
            queue_point(-281857229 + int'($urandom_range(0, 362387866)),
                        -174483046 + int'($urandom_range(0, 348966092)));
        else if (r < 90)
            queue_point(int'($urandom()), int'($urandom()));
        else
            queue_point(pick_edge_value(), pick_edge_value());
    endtask

    // sampled on the falling edge so the sender's updates have settled
    task automatic wait_idle();
        while (pending_points.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        iter_limit = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] limit, input int n);
        wait_idle();
        set_limit(limit);
        for (int i = 0; i < n; i++)
            queue_random_point();
    endtask

    // sender: one transaction at a time, prediction taken when it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            tx_gap = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                accepted_point.c_re = s_axis_tdata[C_W-1:0];
                accepted_point.c_im = s_axis_tdata[2*C_W-1:C_W];
                accepted_point.count = escape_count(accepted_point.c_re, accepted_point.c_im,
                                                    iter_limit);
                expected_counts.push_back(accepted_point);
            end
            if (tx_gap != 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_points.size() != 0)
            begin
                tx_item = pending_points.pop_front();
                s_axis_tdata <= {{(IN_TDATA_W-2*C_W){1'b0}}, tx_item.c_im, tx_item.c_re};
                s_axis_tvalid <= 1'b1;
                tx_gap = idle_len(tx_calm);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: check each transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_counts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: iteration_count %0d",
                                 m_axis_tdata[CNT_W-1:0]);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (m_axis_tdata[CNT_W-1:0] !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("iteration_count mismatch for c=(%0d,%0d): expected %0d got %0d",
                                     want.c_re, want.c_im, want.count,
                                     m_axis_tdata[CNT_W-1:0]);
                    end
                end
                rx_stall = idle_len(rx_calm);
            end
            else if (rx_stall == 0 && !m_axis_tvalid && $urandom_range(0, 19) == 0)
                rx_stall = idle_len(rx_calm);
            if (hold_left != 0 || rx_stall != 0)
            begin
                m_axis_tready <= 1'b0;
                if (rx_stall != 0)
                    rx_stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // one long back-pressure stretch while the sender still has plenty queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= 400 && pending_points.size() > 20)
        begin
            hold_left <= 800;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed points under the reset limit
        queue_point(0, 0);
        queue_point(C_MIN, C_MIN);
        queue_point(C_MAX, C_MAX);
        queue_point(C_MIN, C_MAX);
        queue_point(C_MAX, C_MIN);
        queue_point(C_MIN, 0);
        queue_point(0, C_MAX);
        queue_point(-2 * UNIT, 0);            // |z|^2 lands exactly on 4
        queue_point(2 * UNIT, 0);
        queue_point(0, 2 * UNIT);
        queue_point(0, -2 * UNIT);
        queue_point(-UNIT, 0);                // period-two orbit
        queue_point(0, UNIT);
        queue_point(UNIT / 4, 0);             // cusp, slow convergence
        queue_point(UNIT / 4 + 1, 0);
        queue_point(-3 * UNIT / 4, UNIT / 10);
        queue_point(-7 * UNIT / 4, 0);        // period-three window
        queue_point(-1, 0);
        queue_point(0, -1);
        queue_point(1, 1);
        queue_point(-1, -1);
        queue_point(UNIT / 2, UNIT / 2);
        queue_point(-2 * UNIT, 1);

        run_phase(8'd2, 120);
        run_phase(8'd255, 150);
        run_phase(8'd0, 60);
        run_phase(8'd1, 60);
        run_phase(8'd37, 200);
        run_phase(8'd100, 200);
        for (int k = 0; k < 4; k++)
            run_phase(8'($urandom_range(2, 254)), 135);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
